// ----- hdl/skbs_pkg.sv -----
// ----------------------------------------------------------------------------
// skbs_pkg
// Shared codes for the sorted key-value block store: item modes and status.
// ----------------------------------------------------------------------------
`default_nettype none

package skbs_pkg;

   typedef enum logic [2:0] {
      MD_CLEAR  = 3'd0,
      MD_KEY    = 3'd1,
      MD_VALUE  = 3'd2,
      MD_COMMIT = 3'd3,
      MD_SEARCH = 3'd4,
      MD_LOOKUP = 3'd5,
      MD_READ   = 3'd6,
      MD_NONE   = 3'd7
   } mode_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_FULL      = 3'd1,
      ST_OVERFLOW  = 3'd2,
      ST_KEY_LONG  = 3'd3,
      ST_NOT_FOUND = 3'd4,
      ST_BAD_ADDR  = 3'd5
   } status_type;

   localparam int CAP_W     = 14;
   localparam int CAP_RESET = 4096;

endpackage

`default_nettype wire

// ----- hdl/skbs_ram.sv -----
// ----------------------------------------------------------------------------
// skbs_ram
// Simple dual-address RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module skbs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AB = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AB-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AB-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ----- hdl/sorted_kv_block_store.sv -----
// ----------------------------------------------------------------------------
// sorted_kv_block_store
// Sequencing: idle-mode, clear, key, value, search and commit items and any read or
//   lookup answered at once give their item in the cycle after acceptance; a commit
//   then writes length bytes in S_CW0-S_CW3. A read passes S_RD; a lookup runs S_MID,
//   S_OFF, S_K0, S_K1 and S_ISSUE/S_CMP per compared byte for each probe, then S_V0-S_V2
//   on a hit, paced by the single data-store port. One item in flight at a time.
// Reset clears counters, pending entry and search key; memories are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_kv_block_store #(
   parameter int STORE_BYTES    = 4096,
   parameter int MAX_ENTRIES    = 512,
   parameter int MAX_SEARCH_KEY = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [13:0] csr_wdata,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // byte_in[7:0], address[20:8]
   input  wire logic [2:0]  req_tuser,   // mode[2:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [55:0]      rsp_tdata,   // value_offset[11:0], value_length[23:12],
                                         // byte_out[31:24], entry_total[41:32],
                                         // block_bytes[54:42]
   output logic [2:0]       rsp_tuser    // status[2:0]
);

   localparam int AW  = $clog2(STORE_BYTES);
   localparam int DW  = AW + 1;
   localparam int EW  = $clog2(MAX_ENTRIES + 1);
   localparam int TW  = $clog2(MAX_ENTRIES);
   localparam int SAW = $clog2(MAX_SEARCH_KEY);
   localparam int SKW = $clog2(MAX_SEARCH_KEY + 2);
   localparam int SW  = DW + EW + 4;

   typedef enum logic [3:0] {
      S_IDLE, S_CW0, S_CW1, S_CW2, S_CW3,
      S_MID, S_OFF, S_K0, S_K1, S_ISSUE, S_CMP, S_V0, S_V1, S_V2, S_RD
   } state_type;

   state_type state_ff, state_in;
   logic [skbs_pkg::CAP_W-1:0] cap_ff;
   logic [EW-1:0]  ec_ff, ec_in, lo_ff, lo_in, hi_ff, hi_in, mid;
   logic [DW-1:0]  de_ff, de_in, pk_ff, pk_in, pv_ff, pv_in;
   logic           pov_ff, pov_in;
   logic [SKW-1:0] skl_ff, skl_in, lkl_ff, lkl_in, i_ff, i_in;
   logic [AW-1:0]  o_ff, o_in, cb_ff, cb_in;
   logic [7:0]     klo_ff, klo_in;
   logic [15:0]    klen_ff, klen_in, ck_ff, ck_in, cv_ff, cv_in;
   logic           rtab_ff, rtab_in, rdat_ff, rdat_in, rhi_ff, rhi_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [2:0]     rsp_status_ff, rsp_status_in;
   logic [11:0]    rsp_voff_ff, rsp_voff_in, rsp_vlen_ff, rsp_vlen_in;
   logic [7:0]     rsp_bout_ff, rsp_bout_in;
   logic [9:0]     rsp_ent_ff, rsp_ent_in;
   logic [12:0]    rsp_bytes_ff, rsp_bytes_in;

   logic           d_we, t_we, k_we;
   logic [AW-1:0]  d_wa, d_ra;
   logic [7:0]     d_wd, d_rd, k_wd, k_rd;
   logic [TW-1:0]  t_wa, t_ra;
   logic [AW-1:0]  t_wd, t_rd;
   logic [SAW-1:0] k_wa, k_ra;

   skbs_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_data (
      .clock(clock), .we(d_we), .waddr(d_wa), .wdata(d_wd), .raddr(d_ra), .rdata(d_rd)
   );
   skbs_ram #(.WIDTH(AW), .DEPTH(MAX_ENTRIES)) u_table (
      .clock(clock), .we(t_we), .waddr(t_wa), .wdata(t_wd), .raddr(t_ra), .rdata(t_rd)
   );
   skbs_ram #(.WIDTH(8), .DEPTH(MAX_SEARCH_KEY)) u_skey (
      .clock(clock), .we(k_we), .waddr(k_wa), .wdata(k_wd), .raddr(k_ra), .rdata(k_rd)
   );

   logic [7:0]  byte_in;
   logic [12:0] address;
   logic        accept;
   skbs_pkg::mode_type mode;

   assign byte_in    = req_tdata[7:0];
   assign address    = req_tdata[20:8];
   assign mode       = skbs_pkg::mode_type'(req_tuser);
   assign req_tready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign mid        = EW'(((EW + 1)'(lo_ff) + (EW + 1)'(hi_ff) - (EW + 1)'(1)) >> 1);

   logic [SW-1:0] img, img_in, addr_w, rel;
   logic [DW+1:0] p_key, p_val, fit;
   logic          fin, step, step_lt;
   logic [2:0]    fin_status;
   logic [11:0]   fin_voff, fin_vlen;
   logic [7:0]    fin_bout;
   logic [15:0]   word;

   assign img    = SW'(de_ff) + (SW'(ec_ff) << 1) + SW'(2);
   assign addr_w = SW'(address);
   assign rel    = addr_w - SW'(de_ff);
   assign p_key  = (DW + 2)'(de_ff) + (DW + 2)'(2) + (DW + 2)'(pk_ff);
   assign p_val  = (DW + 2)'(de_ff) + (DW + 2)'(4) + (DW + 2)'(pk_ff) + (DW + 2)'(pv_ff);
   assign fit    = (DW + 2)'(de_ff) + (DW + 2)'(4) + (DW + 2)'(pk_ff) + (DW + 2)'(pv_ff);

   always_comb begin
      state_in = state_ff;
      ec_in = ec_ff; de_in = de_ff; pk_in = pk_ff; pv_in = pv_ff; pov_in = pov_ff;
      skl_in = skl_ff; lkl_in = lkl_ff; i_in = i_ff; lo_in = lo_ff; hi_in = hi_ff;
      o_in = o_ff; cb_in = cb_ff; klo_in = klo_ff; klen_in = klen_ff;
      ck_in = ck_ff; cv_in = cv_ff;
      rtab_in = rtab_ff; rdat_in = rdat_ff; rhi_in = rhi_ff;
      d_we = 1'b0; d_wa = '0; d_wd = '0; d_ra = '0;
      t_we = 1'b0; t_wa = '0; t_wd = '0; t_ra = '0;
      k_we = 1'b0; k_wa = '0; k_wd = '0; k_ra = '0;
      fin = 1'b0; fin_status = skbs_pkg::ST_OK;
      fin_voff = '0; fin_vlen = '0; fin_bout = '0;
      step = 1'b0; step_lt = 1'b0; word = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               fin = 1'b1;
               unique case (mode)
                  skbs_pkg::MD_CLEAR: begin
                     ec_in = '0; de_in = '0; pk_in = '0; pv_in = '0;
                     pov_in = 1'b0; skl_in = '0;
                  end
                  skbs_pkg::MD_KEY: begin
                     if (pv_ff == '0) begin
                        if (p_key < (DW + 2)'(STORE_BYTES)) begin
                           d_we = 1'b1; d_wa = AW'(p_key); d_wd = byte_in;
                           pk_in = pk_ff + DW'(1);
                        end else begin
                           pov_in = 1'b1; fin_status = skbs_pkg::ST_OVERFLOW;
                        end
                     end
                  end
                  skbs_pkg::MD_VALUE: begin
                     if (p_val < (DW + 2)'(STORE_BYTES)) begin
                        d_we = 1'b1; d_wa = AW'(p_val); d_wd = byte_in;
                        pv_in = pv_ff + DW'(1);
                     end else begin
                        pov_in = 1'b1; fin_status = skbs_pkg::ST_OVERFLOW;
                     end
                  end
                  skbs_pkg::MD_COMMIT: begin
                     if (ec_ff != '0 && (img + SW'(pk_ff) + SW'(pv_ff) + SW'(6))
                                       > SW'(cap_ff)) begin
                        fin_status = skbs_pkg::ST_FULL;
                     end else if (pov_ff || fit > (DW + 2)'(STORE_BYTES)
                                  || ec_ff >= EW'(MAX_ENTRIES)) begin
                        fin_status = skbs_pkg::ST_OVERFLOW;
                     end else begin
                        cb_in = AW'(de_ff); ck_in = 16'(pk_ff); cv_in = 16'(pv_ff);
                        ec_in = ec_ff + EW'(1);
                        de_in = DW'(fit);
                        state_in = S_CW0;
                     end
                     pk_in = '0; pv_in = '0; pov_in = 1'b0;
                  end
                  skbs_pkg::MD_SEARCH: begin
                     if (skl_ff < SKW'(MAX_SEARCH_KEY)) begin
                        k_we = 1'b1; k_wa = SAW'(skl_ff); k_wd = byte_in;
                        skl_in = skl_ff + SKW'(1);
                     end else begin
                        skl_in = SKW'(MAX_SEARCH_KEY + 1);
                        fin_status = skbs_pkg::ST_KEY_LONG;
                     end
                  end
                  skbs_pkg::MD_LOOKUP: begin
                     skl_in = '0;
                     if (skl_ff > SKW'(MAX_SEARCH_KEY)) begin
                        fin_status = skbs_pkg::ST_KEY_LONG;
                     end else if (ec_ff == '0) begin
                        fin_status = skbs_pkg::ST_NOT_FOUND;
                     end else begin
                        fin = 1'b0;
                        lkl_in = skl_ff; lo_in = '0; hi_in = ec_ff;
                        state_in = S_MID;
                     end
                  end
                  skbs_pkg::MD_READ: begin
                     if (addr_w >= img) begin
                        fin_status = skbs_pkg::ST_BAD_ADDR;
                     end else begin
                        fin = 1'b0;
                        state_in = S_RD;
                        rdat_in = addr_w < SW'(de_ff);
                        rtab_in = (rel >> 1) < SW'(ec_ff);
                        rhi_in = rel[0];
                        d_ra = AW'(address);
                        t_ra = TW'(rel >> 1);
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_CW0: begin
            d_we = 1'b1; d_wa = cb_ff; d_wd = ck_ff[7:0];
            t_we = 1'b1; t_wa = TW'(ec_ff - EW'(1)); t_wd = cb_ff;
            state_in = S_CW1;
         end
         S_CW1: begin
            d_we = 1'b1; d_wa = AW'(17'(cb_ff) + 17'(1)); d_wd = ck_ff[15:8];
            state_in = S_CW2;
         end
         S_CW2: begin
            d_we = 1'b1; d_wa = AW'(17'(cb_ff) + 17'(2) + 17'(ck_ff)); d_wd = cv_ff[7:0];
            state_in = S_CW3;
         end
         S_CW3: begin
            d_we = 1'b1; d_wa = AW'(17'(cb_ff) + 17'(3) + 17'(ck_ff)); d_wd = cv_ff[15:8];
            state_in = S_IDLE;
         end
         S_MID: begin
            t_ra = TW'(mid);
            state_in = S_OFF;
         end
         S_OFF: begin
            o_in = t_rd; d_ra = t_rd;
            state_in = S_K0;
         end
         S_K0: begin
            klo_in = d_rd;
            d_ra = AW'(17'(o_ff) + 17'(1));
            state_in = S_K1;
         end
         S_K1: begin
            klen_in = {d_rd, klo_ff};
            i_in = '0;
            state_in = S_ISSUE;
         end
         S_ISSUE: begin
            if (16'(i_ff) < klen_ff && i_ff < lkl_ff) begin
               d_ra = AW'(17'(o_ff) + 17'(2) + 17'(i_ff));
               k_ra = SAW'(i_ff);
               state_in = S_CMP;
            end else if (klen_ff == 16'(lkl_ff)) begin
               state_in = S_V0;
            end else begin
               step = 1'b1; step_lt = klen_ff < 16'(lkl_ff);
            end
         end
         S_CMP: begin
            if (d_rd != k_rd) begin
               step = 1'b1; step_lt = d_rd < k_rd;
            end else begin
               i_in = i_ff + SKW'(1);
               state_in = S_ISSUE;
            end
         end
         S_V0: begin
            d_ra = AW'(17'(o_ff) + 17'(2) + 17'(klen_ff));
            state_in = S_V1;
         end
         S_V1: begin
            klo_in = d_rd;
            d_ra = AW'(17'(o_ff) + 17'(3) + 17'(klen_ff));
            state_in = S_V2;
         end
         S_V2: begin
            fin = 1'b1;
            fin_voff = 12'(17'(o_ff) + 17'(4) + 17'(klen_ff));
            fin_vlen = {d_rd[3:0], klo_ff};
            state_in = S_IDLE;
         end
         S_RD: begin
            fin = 1'b1;
            word = rtab_ff ? 16'(t_rd) : 16'(ec_ff);
            if (rdat_ff) begin
               fin_bout = d_rd;
            end else begin
               fin_bout = rhi_ff ? word[15:8] : word[7:0];
            end
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (step) begin
         if (step_lt) begin
            lo_in = mid + EW'(1);
         end else begin
            hi_in = mid;
         end
         if (lo_in < hi_in) begin
            state_in = S_MID;
         end else begin
            fin = 1'b1; fin_status = skbs_pkg::ST_NOT_FOUND;
            state_in = S_IDLE;
         end
      end

      img_in = SW'(de_in) + (SW'(ec_in) << 1) + SW'(2);

      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff; rsp_voff_in = rsp_voff_ff; rsp_vlen_in = rsp_vlen_ff;
      rsp_bout_in = rsp_bout_ff; rsp_ent_in = rsp_ent_ff; rsp_bytes_in = rsp_bytes_ff;
      if (fin) begin
         rsp_valid_in = 1'b1;
         rsp_status_in = fin_status; rsp_voff_in = fin_voff; rsp_vlen_in = fin_vlen;
         rsp_bout_in = fin_bout; rsp_ent_in = 10'(ec_in); rsp_bytes_in = 13'(img_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cap_ff <= skbs_pkg::CAP_W'(skbs_pkg::CAP_RESET);
         ec_ff <= '0; de_ff <= '0; pk_ff <= '0; pv_ff <= '0; pov_ff <= 1'b0;
         skl_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            cap_ff <= csr_wdata;
         end
         ec_ff <= ec_in; de_ff <= de_in; pk_ff <= pk_in; pv_ff <= pv_in; pov_ff <= pov_in;
         skl_ff <= skl_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lkl_ff <= lkl_in; i_ff <= i_in; lo_ff <= lo_in; hi_ff <= hi_in;
      o_ff <= o_in; cb_ff <= cb_in; klo_ff <= klo_in; klen_ff <= klen_in;
      ck_ff <= ck_in; cv_ff <= cv_in;
      rtab_ff <= rtab_in; rdat_ff <= rdat_in; rhi_ff <= rhi_in;
      rsp_status_ff <= rsp_status_in; rsp_voff_ff <= rsp_voff_in;
      rsp_vlen_ff <= rsp_vlen_in; rsp_bout_ff <= rsp_bout_in;
      rsp_ent_ff <= rsp_ent_in; rsp_bytes_ff <= rsp_bytes_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {1'b0, rsp_bytes_ff, rsp_ent_ff, rsp_bout_ff, rsp_vlen_ff, rsp_voff_ff};

endmodule

`default_nettype wire

// ----- tb/sv/sorted_kv_block_store_tb.sv -----
// ----------------------------------------------------------------------------
// sorted_kv_block_store_tb
// Drives entry building, searches and image reads into the block store and
// compares every response against a behavioral block model kept in the bench,
// over several capacity settings and idle patterns on both stream sides.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_kv_block_store_tb;

   localparam int STORE_BYTES    = 4096;
   localparam int MAX_ENTRIES    = 512;
   localparam int MAX_SEARCH_KEY = 256;

   typedef struct packed {
      skbs_pkg::status_type st;
      logic [11:0] voff;
      logic [11:0] vlen;
      logic [7:0]  bout;
      logic [9:0]  entries;
      logic [12:0] bbytes;
   } rsp_item_type;

   typedef struct {
      skbs_pkg::mode_type   md;
      logic [7:0]           b;
      logic [12:0]          addr;
      bit                   typed;
      skbs_pkg::status_type st;
   } stim_row_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_we = 0;
   logic [13:0] csr_wdata = '0;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // byte_in[7:0], address[20:8]
   logic [2:0]  req_tuser = '0;   // mode[2:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [55:0] rsp_tdata;        // value_offset, value_length, byte_out, entry_total,
                                  // block_bytes
   logic [2:0]  rsp_tuser;        // status[2:0]

   sorted_kv_block_store DUT (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   always #2 clock = ~clock;

   // block model state
   logic [7:0]  blk_store [STORE_BYTES];
   logic [11:0] blk_offsets [MAX_ENTRIES];
   logic [7:0]  blk_search [MAX_SEARCH_KEY];
   int unsigned blk_cap = skbs_pkg::CAP_RESET;
   int unsigned blk_count, blk_end, pend_klen, pend_vlen, srch_len;
   bit          pend_ovf;

   rsp_item_type expected_rsps [$];
   int          errors = 0;
   int          sent = 0;
   int          send_idle = 0;
   int          recv_stall = 0;

   function automatic int unsigned blk_rd(int unsigned a);
      return a < STORE_BYTES ? blk_store[a] : 0;
   endfunction

   function automatic int unsigned blk_rd16(int unsigned a);
      return blk_rd(a) | (blk_rd(a + 1) << 8);
   endfunction

   function automatic int unsigned image_size();
      return blk_end + 2 * blk_count + 2;
   endfunction

   function automatic void blk_wr(int unsigned a, int unsigned v);
      if (a < STORE_BYTES) blk_store[a] = v[7:0];
   endfunction

   function automatic int key_order(int unsigned o);
      int unsigned klen, n, a, b;
      klen = blk_rd16(o);
      n = klen < srch_len ? klen : srch_len;
      for (int unsigned i = 0; i < n; i++) begin
         a = blk_rd(o + 2 + i);
         b = blk_search[i];
         if (a != b) return a < b ? -1 : 1;
      end
      if (klen == srch_len) return 0;
      return klen < srch_len ? -1 : 1;
   endfunction

   function automatic rsp_item_type block_step(skbs_pkg::mode_type md, logic [7:0] b,
                                               logic [12:0] addr);
      rsp_item_type r;
      int unsigned  p, sz, o, klen, rel, word;
      int           lo, hi, mid, c;
      r = '0;
      r.st = skbs_pkg::ST_OK;
      case (md)
         skbs_pkg::MD_CLEAR: begin
            blk_count = 0; blk_end = 0; pend_klen = 0; pend_vlen = 0;
            pend_ovf = 0; srch_len = 0;
         end
         skbs_pkg::MD_KEY: if (pend_vlen == 0) begin
            p = blk_end + 2 + pend_klen;
            if (p < STORE_BYTES) begin
               blk_wr(p, b); pend_klen++;
            end else begin
               pend_ovf = 1; r.st = skbs_pkg::ST_OVERFLOW;
            end
         end
         skbs_pkg::MD_VALUE: begin
            p = blk_end + 4 + pend_klen + pend_vlen;
            if (p < STORE_BYTES) begin
               blk_wr(p, b); pend_vlen++;
            end else begin
               pend_ovf = 1; r.st = skbs_pkg::ST_OVERFLOW;
            end
         end
         skbs_pkg::MD_COMMIT: begin
            sz = 4 + pend_klen + pend_vlen;
            if (blk_count != 0 && image_size() + pend_klen + pend_vlen + 6 > blk_cap)
               r.st = skbs_pkg::ST_FULL;
            else if (pend_ovf || blk_end + sz > STORE_BYTES || blk_count >= MAX_ENTRIES)
               r.st = skbs_pkg::ST_OVERFLOW;
            else begin
               blk_wr(blk_end, pend_klen);
               blk_wr(blk_end + 1, pend_klen >> 8);
               blk_wr(blk_end + 2 + pend_klen, pend_vlen);
               blk_wr(blk_end + 3 + pend_klen, pend_vlen >> 8);
               blk_offsets[blk_count] = 12'(blk_end);
               blk_count++;
               blk_end += sz;
            end
            pend_klen = 0; pend_vlen = 0; pend_ovf = 0;
         end
         skbs_pkg::MD_SEARCH: begin
            if (srch_len < MAX_SEARCH_KEY) begin
               blk_search[srch_len] = b; srch_len++;
            end else begin
               srch_len = MAX_SEARCH_KEY + 1; r.st = skbs_pkg::ST_KEY_LONG;
            end
         end
         skbs_pkg::MD_LOOKUP: begin
            if (srch_len > MAX_SEARCH_KEY) r.st = skbs_pkg::ST_KEY_LONG;
            else begin
               lo = 0; hi = int'(blk_count) - 1;
               r.st = skbs_pkg::ST_NOT_FOUND;
               while (lo <= hi) begin
                  mid = lo + (hi - lo) / 2;
                  o = blk_offsets[mid];
                  c = key_order(o);
                  if (c == 0) begin
                     klen = blk_rd16(o);
                     r.voff = 12'(o + 4 + klen);
                     r.vlen = 12'(blk_rd16(o + 2 + klen));
                     r.st = skbs_pkg::ST_OK;
                     break;
                  end else if (c < 0) lo = mid + 1;
                  else hi = mid - 1;
               end
            end
            srch_len = 0;
         end
         skbs_pkg::MD_READ: begin
            if (addr >= image_size()) r.st = skbs_pkg::ST_BAD_ADDR;
            else if (addr < blk_end) r.bout = 8'(blk_rd(addr));
            else begin
               rel = addr - blk_end;
               word = (rel >> 1) < blk_count ? blk_offsets[rel >> 1] : blk_count;
               r.bout = rel[0] ? word[15:8] : word[7:0];
            end
         end
         default: ;
      endcase
      r.entries = 10'(blk_count);
      r.bbytes = 13'(image_size());
      return r;
   endfunction

   task automatic report(string what, int got, int want);
      $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
      errors++;
   endtask

   // sender: valid stays high across back-to-back items
   task automatic send_item(skbs_pkg::mode_type md, logic [7:0] b, logic [12:0] addr,
                            bit typed = 0, skbs_pkg::status_type st = skbs_pkg::ST_OK);
      rsp_item_type e;
      @(negedge clock);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid = 0;
         @(negedge clock);
      end
      req_tvalid = 1;
      req_tuser = md;
      req_tdata = {3'b000, addr, b};
      do @(posedge clock); while (!req_tready);
      e = block_step(md, b, addr);
      if (typed) e.st = st;
      expected_rsps.insert(expected_rsps.size(), e);
      sent++;
   endtask

   task automatic go_idle();
      @(negedge clock);
      req_tvalid = 0;
      while (expected_rsps.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_capacity(logic [13:0] cap);
      go_idle();
      csr_we = 1;
      csr_wdata = cap;
      @(negedge clock);
      csr_we = 0;
      blk_cap = cap;
   endtask

   always @(negedge clock) rsp_tready = $urandom_range(99) >= recv_stall;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_rsps.size() == 0) report("unexpected item", rsp_tuser, 0);
         else begin
            rsp_item_type e;
            e = expected_rsps.pop_front();
            if (rsp_tuser !== e.st) report("status", rsp_tuser, e.st);
            if (rsp_tdata[11:0] !== e.voff) report("value_offset", rsp_tdata[11:0], e.voff);
            if (rsp_tdata[23:12] !== e.vlen) report("value_length", rsp_tdata[23:12], e.vlen);
            if (rsp_tdata[31:24] !== e.bout) report("byte_out", rsp_tdata[31:24], e.bout);
            if (rsp_tdata[41:32] !== e.entries)
               report("entry_total", rsp_tdata[41:32], e.entries);
            if (rsp_tdata[54:42] !== e.bbytes)
               report("block_bytes", rsp_tdata[54:42], e.bbytes);
         end
      end
   end

   task automatic build_entry(int extra_key, int vals, bit stray_key);
      send_item(skbs_pkg::MD_KEY, 8'(blk_count * 3), '0);
      repeat (extra_key)
         send_item(skbs_pkg::MD_KEY, 8'($urandom_range(255)), 13'($urandom));
      repeat (vals) send_item(skbs_pkg::MD_VALUE, 8'($urandom_range(255)), 13'($urandom));
      if (stray_key) send_item(skbs_pkg::MD_KEY, 8'($urandom_range(255)), '0);
      send_item(skbs_pkg::MD_COMMIT, 8'($urandom), 13'($urandom));
   endtask

   task automatic search_for(bit stored);
      int unsigned o, klen, n;
      if (stored && blk_count != 0) begin
         o = blk_offsets[$urandom_range(blk_count - 1)];
         klen = blk_rd16(o);
         n = ($urandom_range(9) == 0 && klen > 0) ? klen - 1 : klen;
         for (int unsigned i = 0; i < n; i++)
            send_item(skbs_pkg::MD_SEARCH, 8'(blk_rd(o + 2 + i)), '0);
      end else
         repeat ($urandom_range(4))
            send_item(skbs_pkg::MD_SEARCH, 8'($urandom_range(255)), '0);
      send_item(skbs_pkg::MD_LOOKUP, 8'($urandom), 13'($urandom));
   endtask

   task automatic random_traffic(int count);
      int start, r;
      start = sent;
      while (sent - start < count) begin
         r = $urandom_range(99);
         if (r < 3) send_item(skbs_pkg::MD_CLEAR, '0, '0);
         else if (r < 45)
            build_entry($urandom_range(3), $urandom_range(9) == 0 ? $urandom_range(20, 60)
                        : $urandom_range(4), $urandom_range(9) == 0);
         else if (r < 70) search_for($urandom_range(3) != 0);
         else if (r < 90)
            send_item(skbs_pkg::MD_READ, 8'($urandom),
                      $urandom_range(9) == 0 ? 13'($urandom)
                      : 13'($urandom_range(image_size() + 3)));
         else send_item(skbs_pkg::mode_type'(3'($urandom_range(7))), 8'($urandom),
                        13'($urandom));
      end
   endtask

   task automatic long_search();
      repeat (MAX_SEARCH_KEY + 2)
         send_item(skbs_pkg::MD_SEARCH, 8'($urandom_range(255)), '0);
      send_item(skbs_pkg::MD_LOOKUP, '0, '0);
   endtask

   stim_row_type directed [] = '{
      '{skbs_pkg::MD_READ,   8'h00, 13'd0,    1, skbs_pkg::ST_OK},
      '{skbs_pkg::MD_READ,   8'h00, 13'd8191, 1, skbs_pkg::ST_BAD_ADDR},
      '{skbs_pkg::MD_LOOKUP, 8'h00, 13'd0,    1, skbs_pkg::ST_NOT_FOUND},
      '{skbs_pkg::MD_NONE,   8'hFF, 13'd8191, 1, skbs_pkg::ST_OK},
      '{skbs_pkg::MD_KEY,    8'h00, 13'd0,    0, skbs_pkg::ST_OK},
      '{skbs_pkg::MD_KEY,    8'hFF, 13'd0,    0, skbs_pkg::ST_OK},
      '{skbs_pkg::MD_VALUE,  8'hAA, 13'd0,    0, skbs_pkg::ST_OK},
      '{skbs_pkg::MD_VALUE,  8'h55, 13'd0,    0, skbs_pkg::ST_OK},
      '{skbs_pkg::MD_KEY,    8'h77, 13'd0,    0, skbs_pkg::ST_OK},
      '{skbs_pkg::MD_COMMIT, 8'h00, 13'd0,    0, skbs_pkg::ST_OK},
      '{skbs_pkg::MD_KEY,    8'hFF, 13'd0,    0, skbs_pkg::ST_OK},
      '{skbs_pkg::MD_COMMIT, 8'h00, 13'd0,    0, skbs_pkg::ST_OK},
      '{skbs_pkg::MD_SEARCH, 8'h00, 13'd0,    0, skbs_pkg::ST_OK},
      '{skbs_pkg::MD_SEARCH, 8'hFF, 13'd0,    0, skbs_pkg::ST_OK},
      '{skbs_pkg::MD_LOOKUP, 8'h00, 13'd0,    0, skbs_pkg::ST_OK},
      '{skbs_pkg::MD_SEARCH, 8'h00, 13'd0,    0, skbs_pkg::ST_OK},
      '{skbs_pkg::MD_LOOKUP, 8'h00, 13'd0,    0, skbs_pkg::ST_OK},
      '{skbs_pkg::MD_SEARCH, 8'hFF, 13'd0,    0, skbs_pkg::ST_OK},
      '{skbs_pkg::MD_LOOKUP, 8'h00, 13'd0,    0, skbs_pkg::ST_OK},
      '{skbs_pkg::MD_READ,   8'h00, 13'd3,    0, skbs_pkg::ST_OK},
      '{skbs_pkg::MD_READ,   8'h00, 13'd13,   0, skbs_pkg::ST_OK},
      '{skbs_pkg::MD_READ,   8'h00, 13'd16,   0, skbs_pkg::ST_OK},
      '{skbs_pkg::MD_CLEAR,  8'h00, 13'd0,    0, skbs_pkg::ST_OK},
      '{skbs_pkg::MD_READ,   8'h00, 13'd2,    1, skbs_pkg::ST_BAD_ADDR}
   };

   initial begin
      #(4 * 4_000_000);
      $display("status: fail");
      $finish;
   end

   initial begin
      int idle_send [4] = '{0, 77, 0, 14};
      int idle_recv [4] = '{0, 0, 77, 14};
      logic [13:0] caps [4];
      caps = '{14'(skbs_pkg::CAP_RESET), 14'd0, 14'd16383, 14'($urandom_range(64, 600))};
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 0;
      foreach (directed[i])
         send_item(directed[i].md, directed[i].b, directed[i].addr,
                   directed[i].typed, directed[i].st);
      for (int ph = 0; ph < 4; ph++) begin
         if (ph != 0) write_capacity(caps[ph]);
         send_idle = idle_send[ph];
         recv_stall = idle_recv[ph];
         random_traffic(130);
         if (ph == 3) long_search();
         if (ph == 1) begin
            write_capacity(14'd8192);
            random_traffic(60);
         end
      end
      go_idle();
      repeat (20) @(negedge clock);
      if (errors == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule

`default_nettype wire

// ----- sim.f -----
hdl/skbs_pkg.sv
hdl/skbs_ram.sv
hdl/sorted_kv_block_store.sv
tb/sv/sorted_kv_block_store_tb.sv
